// File: hw/rtl/rdc_pkg.sv
// shared constants and types for the real-number dft impulse corrector
// no dependencies
`default_nettype none

package rdc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int NUM_SAMPLES      = 6;
  localparam int THRESH_WIDTH     = 31;
  localparam int PADDR_WIDTH      = 3;

  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 31'd409600;
  localparam logic [PADDR_WIDTH-1:0]  ADDR_DETECT_THRESHOLD = 3'd0;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

endpackage

`default_nettype wire

// File: hw/rtl/real_dft_code_impulse_corrector.sv
// Systematic (6,4) real-number DFT code encoder and single-impulse corrector for signed
// fixed-point samples. One transaction is accepted per clock cycle while the output is not
// stalled, and each passes the input, syndrome, product, sum and square-root stages before
// the output register; the square root resolves one root bit per stage. Stalls on the
// output side fill pipeline bubbles before the input is held off. detect_threshold sits at
// address 0 of the register port and must only be written while the pipeline is empty.
// depends on rdc_pkg and rdc_lane
`default_nettype none

module real_dft_code_impulse_corrector
  import rdc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // sample_0 .. sample_5 from bit 0 up, zero padded to bytes
  input  logic [((NUM_SAMPLES*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // word_0 .. word_5, error_location, impulse_value from bit 0 up, zero padded
  output logic [((7*SAMPLE_WIDTH+3+7)/8)*8-1:0] m_axis_tdata,
  // error_found
  output logic                   m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int ODW = ((7*W+3+7)/8)*8;
  localparam int RW  = W + 5;
  localparam int AW  = W + 3;
  localparam int H   = (AW + 1) / 2;
  localparam int PW  = 2 * H;
  localparam int SW  = 2 * AW + 2;
  localparam int QW  = 2 * W + 5;
  localparam int TW  = QW + 1;
  localparam int CW  = (SW > 64) ? SW : 64;
  localparam int RT  = W + 3;
  localparam int NP  = 4 + RT;

  localparam logic signed [RW-1:0] SMAX = {{6{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN = {{6{1'b1}}, {(W-1){1'b0}}};

  typedef struct packed {
    op_e                     op;
    logic [5:0][W-1:0]       y;
    logic [AW-1:0]           ar;
    logic [AW-1:0]           ab;
    logic [2:0]              base;
    logic [2:0]              at;
    logic                    neg;
    logic [PW-1:0]           a_hh;
    logic [PW-1:0]           a_hl;
    logic [PW-1:0]           a_ll;
    logic [PW-1:0]           b_hh;
    logic [PW-1:0]           b_hl;
    logic [PW-1:0]           b_ll;
    logic                    hit;
    logic [QW-1:0]           rem;
    logic [RT-1:0]           root;
  } pipe_t;

  typedef struct packed {
    logic [5:0][W-1:0] words;
    logic              found;
    logic [2:0]        loc;
    logic [W-1:0]      emag;
  } out_t;

  function automatic logic [W-1:0] sat_w(input logic signed [RW-1:0] v);
    logic [W-1:0] r;
    if (v > SMAX) begin
      r = SMAX[W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [THRESH_WIDTH-1:0] thr_q;
  logic [63:0]             lim_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_DETECT_THRESHOLD);
  assign prdata = (paddr == ADDR_DETECT_THRESHOLD) ? {1'b0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
      lim_q <= 64'd0;
    end else begin
      if (cfg_wr) begin
        thr_q <= pwdata[THRESH_WIDTH-1:0];
      end
      lim_q <= {thr_q, 1'b0} * {thr_q, 1'b0};
    end
  end

  // pipeline
  pipe_t         pipe_q [NP];
  pipe_t         nxt    [NP];
  logic [NP-1:0] v_q;
  logic [NP:0]   adv;
  out_t          out_q;
  out_t          out_d;
  logic          out_v_q;

  assign adv[NP]       = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv[0];

  for (genvar s = 0; s < NP; s++) begin : g_stage
    assign adv[s] = !v_q[s] || adv[s+1];

    if (s == 0) begin : g_in
      always_comb begin
        nxt[s]    = '0;
        nxt[s].op = op_e'(s_axis_tuser);
        for (int i = 0; i < NUM_SAMPLES; i++) begin
          nxt[s].y[i] = s_axis_tdata[i*W +: W];
        end
      end
    end else if (s == 1) begin : g_synd
      always_comb begin
        logic signed [RW-1:0] x [6];
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] b;
        logic signed [RW-1:0] c3;
        logic [2:0]           k;
        nxt[s] = pipe_q[s-1];
        for (int i = 0; i < NUM_SAMPLES; i++) begin
          x[i] = RW'(signed'(pipe_q[s-1].y[i]));
        end
        r = (x[0] <<< 1) + x[1] - x[2] - (x[3] <<< 1) - x[4] + x[5];
        b = x[1] + x[2] - x[4] - x[5];
        nxt[s].ar = r[RW-1] ? AW'(-r) : AW'(r);
        nxt[s].ab = b[RW-1] ? AW'(-b) : AW'(b);
        c3 = (RW'(nxt[s].ab) <<< 1) + RW'(nxt[s].ab);
        priority if (r > c3) begin
          k = 3'd0;
        end else if (r > 0) begin
          k = 3'd1;
        end else if (r > -c3) begin
          k = 3'd2;
        end else begin
          k = 3'd3;
        end
        if (b[RW-1] && k != 3'd0 && k != 3'd3) begin
          k = 3'd6 - k;
        end
        nxt[s].base = k;
        if (pipe_q[s-1].op == OP_ENCODE) begin
          nxt[s].y[4] = sat_w(x[0] + x[1] - x[3]);
          nxt[s].y[5] = sat_w(x[2] + x[3] - x[0]);
        end
      end
    end else if (s == 2) begin : g_prod
      always_comb begin
        logic [2:0]   alias_loc;
        logic [W-1:0] yb;
        logic [W-1:0] ya;
        logic [W:0]   mb;
        logic [W:0]   ma;
        nxt[s]    = pipe_q[s-1];
        alias_loc = (pipe_q[s-1].base >= 3'd3) ? pipe_q[s-1].base - 3'd3
                                                : pipe_q[s-1].base + 3'd3;
        yb = pipe_q[s-1].y[pipe_q[s-1].base];
        ya = pipe_q[s-1].y[alias_loc];
        mb = yb[W-1] ? (W+1)'(0) - {yb[W-1], yb} : {1'b0, yb};
        ma = ya[W-1] ? (W+1)'(0) - {ya[W-1], ya} : {1'b0, ya};
        if (mb > ma) begin
          nxt[s].at  = pipe_q[s-1].base;
          nxt[s].neg = 1'b0;
        end else begin
          nxt[s].at  = alias_loc;
          nxt[s].neg = 1'b1;
        end
        nxt[s].a_hh = PW'(pipe_q[s-1].ar[AW-1:H]) * PW'(pipe_q[s-1].ar[AW-1:H]);
        nxt[s].a_hl = PW'(pipe_q[s-1].ar[AW-1:H]) * PW'(pipe_q[s-1].ar[H-1:0]);
        nxt[s].a_ll = PW'(pipe_q[s-1].ar[H-1:0]) * PW'(pipe_q[s-1].ar[H-1:0]);
        nxt[s].b_hh = PW'(pipe_q[s-1].ab[AW-1:H]) * PW'(pipe_q[s-1].ab[AW-1:H]);
        nxt[s].b_hl = PW'(pipe_q[s-1].ab[AW-1:H]) * PW'(pipe_q[s-1].ab[H-1:0]);
        nxt[s].b_ll = PW'(pipe_q[s-1].ab[H-1:0]) * PW'(pipe_q[s-1].ab[H-1:0]);
      end
    end else if (s == 3) begin : g_sum
      always_comb begin
        logic [SW-1:0] qa;
        logic [SW-1:0] qb;
        logic [SW-1:0] q;
        nxt[s] = pipe_q[s-1];
        qa = (SW'(pipe_q[s-1].a_hh) << (2*H)) + (SW'(pipe_q[s-1].a_hl) << (H+1))
           + SW'(pipe_q[s-1].a_ll);
        qb = (SW'(pipe_q[s-1].b_hh) << (2*H)) + (SW'(pipe_q[s-1].b_hl) << (H+1))
           + SW'(pipe_q[s-1].b_ll);
        q  = qa + (qb << 1) + qb;
        nxt[s].rem  = q[QW-1:0];
        nxt[s].root = '0;
        nxt[s].hit  = CW'(q) > CW'(lim_q);
      end
    end else begin : g_sqrt
      localparam int B = RT - 1 - (s - 4);
      always_comb begin
        logic [TW-1:0] trial;
        nxt[s] = pipe_q[s-1];
        trial  = (TW'(pipe_q[s-1].root) << (B+1)) + (TW'(1) << (2*B));
        if (trial <= TW'(pipe_q[s-1].rem)) begin
          nxt[s].rem     = pipe_q[s-1].rem - trial[QW-1:0];
          nxt[s].root[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv[s]) begin
        v_q[s] <= (s == 0) ? s_axis_tvalid : v_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        pipe_q[s] <= nxt[s];
      end
    end
  end

  // correction lanes and merge
  logic [RT:0]           mag;
  logic signed [W+3:0]   sub;
  logic                  corr;
  logic [5:0][W-1:0]     lane_word;

  assign corr = (pipe_q[NP-1].op == OP_DECODE) && pipe_q[NP-1].hit;
  assign mag  = ((RT+1)'(pipe_q[NP-1].root) + (RT+1)'(1)) >> 1;
  assign sub  = pipe_q[NP-1].neg ? -signed'({1'b0, mag[RT-1:0]})
                                 : signed'({1'b0, mag[RT-1:0]});

  for (genvar i = 0; i < NUM_SAMPLES; i++) begin : g_lane
    rdc_lane #(
      .SAMPLE_WIDTH(W)
    ) u_lane (
      .sample_i(pipe_q[NP-1].y[i]),
      .sel_i   (corr && (pipe_q[NP-1].at == 3'(i))),
      .sub_i   (sub),
      .word_o  (lane_word[i])
    );
  end

  always_comb begin
    out_d.words = lane_word;
    out_d.found = corr;
    out_d.loc   = corr ? pipe_q[NP-1].at : 3'd0;
    out_d.emag  = corr ? sat_w(RW'(sub)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv[NP]) begin
      out_v_q <= v_q[NP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NP]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = ODW'({out_q.emag, out_q.loc, out_q.words});

  // a correction always names one of the six samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.found |-> out_q.loc <= 3'd5)
    else $error("correction location out of range");

  // no correction reports neither a location nor a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.found |-> out_q.loc == 3'd0 && out_q.emag == '0)
    else $error("stray error report without correction");

  // an empty output register never holds off the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled output keeps its result until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q && $stable(out_q))
    else $error("pending result lost under stall");

endmodule

`default_nettype wire

// File: hw/rtl/rdc_lane.sv
// one sample lane: subtracts the impulse value when selected and saturates
// depends on rdc_pkg
`default_nettype none

module rdc_lane
  import rdc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic                           sel_i,
  input  logic signed [SAMPLE_WIDTH+3:0] sub_i,
  output logic [SAMPLE_WIDTH-1:0]        word_o
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int DW = W + 5;

  localparam logic signed [DW-1:0] SMAX = {{6{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {{6{1'b1}}, {(W-1){1'b0}}};

  logic signed [DW-1:0] diff;

  always_comb begin
    diff = DW'(signed'(sample_i)) - DW'(sub_i);
    if (!sel_i) begin
      word_o = sample_i;
    end else if (diff > SMAX) begin
      word_o = SMAX[W-1:0];
    end else if (diff < SMIN) begin
      word_o = SMIN[W-1:0];
    end else begin
      word_o = diff[W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: tb/real_dft_code_impulse_corrector_tb.sv
// self-checking bench for the (6,4) real-number dft encoder and impulse corrector
// predicts each codeword or correction in the bench and compares in order; needs rdc_pkg
`default_nettype none

module real_dft_code_impulse_corrector_tb;
  import rdc_pkg::*;

  localparam int SW = 32;
  localparam int IN_W = ((NUM_SAMPLES*SW+7)/8)*8;
  localparam int OUT_W = ((7*SW+3+7)/8)*8;
  localparam int LATENCY = SW + 8;

  typedef struct packed {
    logic [SW-1:0] emag;
    logic [2:0]    eloc;
    logic          efound;
    logic [SW-1:0] w5, w4, w3, w2, w1, w0;
  } word_set_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  real_dft_code_impulse_corrector i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  word_set_t expected_words[$];
  logic [30:0] thresh_q = THRESH_RESET;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                 input logic [SW-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [SW-1:0] sat_word(input longint v);
    longint mx = (64'sd1 <<< (SW-1)) - 1;
    if (v > mx) return mx[SW-1:0];
    if (v < -mx - 1) return SW'(-mx - 1);
    return v[SW-1:0];
  endfunction

  // floor square root of a 128-bit value, 52 result bits
  function automatic longint unsigned root_floor(input logic [127:0] q);
    logic [63:0] r = 0;
    logic [63:0] t;
    for (int b = 51; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= q) r = t;
    end
    return r;
  endfunction

  function automatic int sector_of(input longint a, input longint b);
    longint c = (b < 0) ? -b : b;
    int k;
    if (a > 3*c) k = 0;
    else if (a > 0) k = 1;
    else if (a > -3*c) k = 2;
    else k = 3;
    if (b < 0) k = (6 - k) % 6;
    return k;
  endfunction

  function automatic word_set_t correct_words(input op_e op,
                                              input logic [SW-1:0] smp [6]);
    longint y[6];
    longint r, b, mag, sub;
    logic [127:0] q, lim, ar, ab, t2;
    int base, alias_loc, at;
    word_set_t w;
    for (int i = 0; i < 6; i++) y[i] = longint'($signed(smp[i]));
    w.efound = 1'b0;
    w.eloc = '0;
    w.emag = '0;
    if (op == OP_ENCODE) begin
      y[4] = sat_word(y[0] + y[1] - y[3]);
      y[5] = sat_word(-y[0] + y[2] + y[3]);
    end else begin
      r = 2*y[0] + y[1] - y[2] - 2*y[3] - y[4] + y[5];
      b = y[1] + y[2] - y[4] - y[5];
      ar = (r < 0) ? -r : r;
      ab = (b < 0) ? -b : b;
      q = ar*ar + 3*ab*ab;
      t2 = 2 * thresh_q;
      lim = t2 * t2;
      if (q > lim) begin
        mag = longint'((root_floor(q) + 1) >> 1);
        base = sector_of(r, b);
        alias_loc = (base + 3) % 6;
        if (((y[base] < 0) ? -y[base] : y[base]) >
            ((y[alias_loc] < 0) ? -y[alias_loc] : y[alias_loc])) begin
          at = base;
          sub = mag;
        end else begin
          at = alias_loc;
          sub = -mag;
        end
        y[at] = sat_word(y[at] - sub);
        w.efound = 1'b1;
        w.eloc = 3'(at);
        w.emag = sat_word(sub);
      end
    end
    w.w0 = y[0][SW-1:0]; w.w1 = y[1][SW-1:0]; w.w2 = y[2][SW-1:0];
    w.w3 = y[3][SW-1:0]; w.w4 = y[4][SW-1:0]; w.w5 = y[5][SW-1:0];
    return w;
  endfunction

  task automatic send_codeword(input op_e op, input logic [SW-1:0] smp [6]);
    logic [IN_W-1:0] d = '0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    for (int i = 0; i < 6; i++) d[i*SW +: SW] = smp[i];
    s_axis_tdata <= d;
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_words.push_back(correct_words(op, smp));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    word_set_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.w0 = m_axis_tdata[0*SW +: SW]; got.w1 = m_axis_tdata[1*SW +: SW];
      got.w2 = m_axis_tdata[2*SW +: SW]; got.w3 = m_axis_tdata[3*SW +: SW];
      got.w4 = m_axis_tdata[4*SW +: SW]; got.w5 = m_axis_tdata[5*SW +: SW];
      got.eloc = m_axis_tdata[6*SW +: 3];
      got.emag = m_axis_tdata[6*SW+3 +: SW];
      got.efound = m_axis_tuser;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
      end else begin
        want = expected_words.pop_front();
        if (got.w0 !== want.w0) report_mismatch("word_0", got.w0, want.w0);
        if (got.w1 !== want.w1) report_mismatch("word_1", got.w1, want.w1);
        if (got.w2 !== want.w2) report_mismatch("word_2", got.w2, want.w2);
        if (got.w3 !== want.w3) report_mismatch("word_3", got.w3, want.w3);
        if (got.w4 !== want.w4) report_mismatch("word_4", got.w4, want.w4);
        if (got.w5 !== want.w5) report_mismatch("word_5", got.w5, want.w5);
        if (got.efound !== want.efound)
          report_mismatch("error_found", SW'(got.efound), SW'(want.efound));
        if (got.eloc !== want.eloc)
          report_mismatch("error_location", SW'(got.eloc), SW'(want.eloc));
        if (got.emag !== want.emag)
          report_mismatch("impulse_value", got.emag, want.emag);
      end
    end
  end

  task automatic drain_pipeline;
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [30:0] value);
    logic [31:0] rd;
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_DETECT_THRESHOLD; pwdata <= {1'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thresh_q = value;
    @(negedge clk_i);
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    #1 rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if (rd[30:0] !== value) report_mismatch("detect_threshold readback", rd, {1'b0, value});
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  // encode requests, raw decode words and valid codewords, most with one impulse, so the corrector path is exercised
  task automatic send_random_item;
    logic [SW-1:0] smp [6];
    longint m[4];
    int loc;
    for (int i = 0; i < 6; i++) smp[i] = rand_sample();
    if ($urandom_range(9) < 2) begin
      send_codeword(OP_ENCODE, smp);
    end else begin
      if ($urandom_range(9) < 7) begin
        for (int i = 0; i < 4; i++) m[i] = $signed($urandom_range(400000)) - 200000;
        smp[0] = SW'(m[0]); smp[1] = SW'(m[1]); smp[2] = SW'(m[2]); smp[3] = SW'(m[3]);
        smp[4] = SW'(m[0] + m[1] - m[3]);
        smp[5] = SW'(-m[0] + m[2] + m[3]);
        loc = $urandom_range(5);
        if ($urandom_range(3) != 0)
          smp[loc] = smp[loc] + rand_sample();
      end
      send_codeword(OP_DECODE, smp);
    end
  endtask

  task automatic test_directed;
    logic [SW-1:0] smp [6];
    logic [SW-1:0] vals [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 6; i++) smp[i] = vals[(k + i) % 4];
      send_codeword(OP_ENCODE, smp);
      send_codeword(OP_DECODE, smp);
    end
    // impulses on each location, and sector-line ties
    for (int l = 0; l < 6; l++) begin
      for (int i = 0; i < 6; i++) smp[i] = '0;
      smp[l] = (l % 2) ? 32'h7fffffff : 32'hfff00000;
      send_codeword(OP_DECODE, smp);
    end
    for (int i = 0; i < 6; i++) smp[i] = '0;
    smp[1] = 32'd3000000; smp[2] = 32'd3000000;
    send_codeword(OP_DECODE, smp);
    smp[1] = 32'd3000000; smp[2] = -32'sd3000000;
    send_codeword(OP_DECODE, smp);
    for (int i = 0; i < 6; i++) smp[i] = 32'h80000000;
    send_codeword(OP_DECODE, smp);
    for (int i = 0; i < 6; i++) smp[i] = i[0] ? 32'h80000000 : 32'h7fffffff;
    send_codeword(OP_DECODE, smp);
    drain_pipeline();
  endtask

  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random_item();
    drain_pipeline();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (150) send_random_item();
    join
    drain_pipeline();
  endtask

  task automatic test_thresholds;
    logic [30:0] levels [3] = '{31'd0, 31'h7fffffff, 31'd4096};
    foreach (levels[i]) begin
      write_threshold(levels[i]);
      test_random_phase(100, 28, 28);
    end
    write_threshold(THRESH_RESET);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_phase(350, 0, 0);
    test_random_phase(350, 71, 0);
    test_random_phase(350, 0, 71);
    test_random_phase(350, 28, 28);
    test_backpressure();
    test_thresholds();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
